// ===== rtl/core/encoder_speed_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// encoder_speed_estimator_macros.svh
// Assertion macros used by the speed estimator checker.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_ESTIMATOR_MACROS_SVH
`define ENCODER_SPEED_ESTIMATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define ESP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ESP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/esp_pkg.sv =====
// ----------------------------------------------------------------------------
// esp_pkg
// Widths, reset values, codes and the microprogram of the speed estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

   localparam int CHANNELS   = 4;
   localparam int CH_W       = 2;
   localparam int CNT_W      = 32;
   localparam int SPD_W      = 32;
   localparam int SCALE_W    = 24;
   localparam int GAIN_W     = 17;
   localparam int MASK_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // shared multiplier: signed 33 x signed 25
   localparam int OPA_W  = 33;
   localparam int OPB_W  = 25;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int ACC_W  = 50;
   localparam int FRAC_W = 16;

   localparam int STEP_W = 3;

   localparam logic [SCALE_W-1:0] SCALE_RST = 24'd205783;
   localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd16384;
   localparam logic [MASK_W-1:0]  MASK_RST  = 4'd12;
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_SCALE = 2'd0,
      CSR_FILTER_GAIN = 2'd1,
      CSR_NARROW_MASK = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      OPA_DELTA,
      OPA_RAW,
      OPA_OLD
   } opa_sel_type;

   typedef enum logic [1:0] {
      OPB_SCALE,
      OPB_GAIN,
      OPB_COGAIN
   } opb_sel_type;

   typedef struct packed {
      logic        delta_en;   // form count delta, fetch old filter value
      opa_sel_type opa;
      opb_sel_type opb;
      logic        mul_en;
      logic        raw_en;     // negate and saturate product into raw speed
      logic        acc_ld;
      logic        acc_add;
      logic        fin;        // round, write back, present result
      logic        wait_out;   // hold this step while the result register is still unread
   } ucode_type;

   typedef struct packed {
      ucode_type uc;
      logic      commit;
   } ctrl_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         3'd0: w.delta_en = 1'b1;
         3'd1: begin
            w.mul_en = 1'b1;
            w.opa    = OPA_DELTA;
            w.opb    = OPB_SCALE;
         end
         3'd2: w.raw_en = 1'b1;
         3'd3: begin
            w.mul_en = 1'b1;
            w.opa    = OPA_RAW;
            w.opb    = OPB_GAIN;
         end
         3'd4: begin
            w.acc_ld = 1'b1;
            w.mul_en = 1'b1;
            w.opa    = OPA_OLD;
            w.opb    = OPB_COGAIN;
         end
         3'd5: w.acc_add = 1'b1;
         3'd6: begin
            w.fin      = 1'b1;
            w.wait_out = 1'b1;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esp_sequencer.sv =====
// ----------------------------------------------------------------------------
// esp_sequencer
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_sequencer import esp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic out_stall,
   output ctrl_type  ctrl,
   output logic      ready,
   output logic      rsp_valid
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ucode_type         uc;
   logic              hold;
   logic              commit;

   assign uc     = ucode_rom(step_ff);
   // conditional jump back to the same step while the old result is unread
   assign hold   = busy_ff && uc.fin && uc.wait_out && rsp_valid_ff && out_stall;
   assign commit = busy_ff && uc.fin && !hold;

   always_comb begin
      step_in      = step_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && out_stall;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (commit) begin
         step_in = '0;
         busy_in = 1'b0;
      end else if (busy_ff && !hold) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign ctrl.uc     = busy_ff ? uc : '0;
   assign ctrl.commit = commit;
   assign ready       = !busy_ff || commit;
   assign rsp_valid   = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/esp_datapath.sv =====
// ----------------------------------------------------------------------------
// esp_datapath
// Channel state, delta fold, shared multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_datapath import esp_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [CH_W-1:0]          in_channel,
   input  wire logic [CNT_W-1:0]         in_count,
   input  wire logic [SCALE_W-1:0]       speed_scale,
   input  wire logic [GAIN_W-1:0]        filter_gain,
   input  wire logic [MASK_W-1:0]        narrow_mask,
   input  wire ctrl_type                 ctrl,
   output logic [CH_W-1:0]               out_channel,
   output logic signed [SPD_W-1:0]       out_raw,
   output logic signed [SPD_W-1:0]       out_smooth
);

   function automatic logic [SPD_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-SPD_W:0] top;
      top = v[PROD_W-1:SPD_W-1];
      if (!v[PROD_W-1] && (top != '0))
         return {1'b0, {(SPD_W-1){1'b1}}};
      if (v[PROD_W-1] && (top != '1))
         return {1'b1, {(SPD_W-1){1'b0}}};
      return v[SPD_W-1:0];
   endfunction

   function automatic logic [SPD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-SPD_W:0] top;
      top = v[ACC_W-1:SPD_W-1];
      if (!v[ACC_W-1] && (top != '0))
         return {1'b0, {(SPD_W-1){1'b1}}};
      if (v[ACC_W-1] && (top != '1))
         return {1'b1, {(SPD_W-1){1'b0}}};
      return v[SPD_W-1:0];
   endfunction

   logic [CNT_W-1:0]         prev_ff [CHANNELS];
   logic [CNT_W-1:0]         prev_in [CHANNELS];
   logic signed [SPD_W-1:0]  filt_ff [CHANNELS];
   logic signed [SPD_W-1:0]  filt_in [CHANNELS];

   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [CNT_W-1:0]  delta_ff, delta_in;
   logic signed [SPD_W-1:0]  old_ff, old_in;
   logic signed [SPD_W-1:0]  raw_ff, raw_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CH_W-1:0]          och_ff, och_in;
   logic signed [SPD_W-1:0]  oraw_ff, oraw_in;
   logic signed [SPD_W-1:0]  osm_ff, osm_in;

   logic [CNT_W-1:0]         diff;
   logic [GAIN_W-1:0]        gain_eff;
   logic [GAIN_W-1:0]        cogain;
   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [PROD_W-1:0] neg_prod;
   logic signed [ACC_W-1:0]  rnd_sum;
   logic signed [ACC_W-1:0]  rnd_q;
   logic signed [SPD_W-1:0]  smooth;

   assign diff     = cnt_ff - prev_ff[ch_ff];
   assign gain_eff = (filter_gain > GAIN_ONE) ? GAIN_ONE : filter_gain;
   assign cogain   = GAIN_ONE - gain_eff;
   assign neg_prod = -prod_ff;
   // halves round up: floor((sum + half) / 2^16)
   assign rnd_sum  = acc_ff + ACC_W'(32768);
   assign rnd_q    = rnd_sum >>> FRAC_W;
   assign smooth   = sat_acc(rnd_q);

   always_comb begin
      case (ctrl.uc.opa)
         OPA_DELTA: opa = {delta_ff[CNT_W-1], delta_ff};
         OPA_RAW:   opa = {raw_ff[SPD_W-1], raw_ff};
         OPA_OLD:   opa = {old_ff[SPD_W-1], old_ff};
         default:   opa = '0;
      endcase
      case (ctrl.uc.opb)
         OPB_SCALE:  opb = {1'b0, speed_scale};
         OPB_GAIN:   opb = {{(OPB_W-GAIN_W){1'b0}}, gain_eff};
         OPB_COGAIN: opb = {{(OPB_W-GAIN_W){1'b0}}, cogain};
         default:    opb = '0;
      endcase
   end

   always_comb begin
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      delta_in = delta_ff;
      old_in   = old_ff;
      raw_in   = raw_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      och_in   = och_ff;
      oraw_in  = oraw_ff;
      osm_in   = osm_ff;
      prev_in  = prev_ff;
      filt_in  = filt_ff;

      if (start) begin
         ch_in  = in_channel;
         cnt_in = in_count;
      end
      if (ctrl.uc.delta_en) begin
         // 16-bit counters fold the delta into -32768..32767
         if (narrow_mask[ch_ff])
            delta_in = {{(CNT_W-16){diff[15]}}, diff[15:0]};
         else
            delta_in = diff;
         old_in = filt_ff[ch_ff];
      end
      if (ctrl.uc.mul_en) begin
         prod_in = opa * opb;
      end
      if (ctrl.uc.raw_en) begin
         raw_in = sat_prod(neg_prod);
      end
      if (ctrl.uc.acc_ld) begin
         acc_in = prod_ff[ACC_W-1:0];
      end
      if (ctrl.uc.acc_add) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end
      if (ctrl.commit) begin
         filt_in[ch_ff] = smooth;
         prev_in[ch_ff] = cnt_ff;
         och_in         = ch_ff;
         oraw_in        = raw_ff;
         osm_in         = smooth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            prev_ff[i] <= '0;
            filt_ff[i] <= '0;
         end
      end else begin
         prev_ff <= prev_in;
         filt_ff <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      cnt_ff   <= cnt_in;
      delta_ff <= delta_in;
      old_ff   <= old_in;
      raw_ff   <= raw_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      och_ff   <= och_in;
      oraw_ff  <= oraw_in;
      osm_ff   <= osm_in;
   end

   assign out_channel = och_ff;
   assign out_raw     = oraw_ff;
   assign out_smooth  = osm_ff;

endmodule

`default_nettype wire

// ===== rtl/core/encoder_speed_estimator.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// Per-channel encoder speed with exponential smoothing, microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per encoder sample (channel, count). Accepted when
//            req_valid is high and req_stall is low.
//   rsp_*  : one beat per sample: channel, raw speed and smoothed speed, both
//            Q15.16 rad/s. Accepted when rsp_valid is high and rsp_stall low.
//   csr_*  : register writes (0 speed_scale, 1 filter_gain, 2 narrow mask),
//            always ready; write only while no sample is in flight.
// The result register is written by the last step of the microprogram.
// Samples are processed one at a time by the seven-step microprogram
//   that runs every sample through one shared 33x25 multiplier.
// The request is taken in the cycle its predecessor's result is written, so
//   a new sample enters while the result register still waits to be read.
// A stalled response holds; the last step waits on it before overwriting.
// Reset: registers return to their defaults, all stored counts and filter
//   states clear to zero, no result is pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_estimator import esp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CH_W-1:0]         req_channel,
   input  wire logic [CNT_W-1:0]        req_count_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [CH_W-1:0]              rsp_channel_out,
   output logic signed [SPD_W-1:0]      rsp_unfiltered_speed,
   output logic signed [SPD_W-1:0]      rsp_smooth_speed,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   ctrl_type ctrl;
   logic     ready;
   logic     accept;
   logic     start;

   assign csr_ready = 1'b1;

   always_comb begin
      scale_in = scale_ff;
      gain_in  = gain_ff;
      mask_in  = mask_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SPEED_SCALE: scale_in = csr_data[SCALE_W-1:0];
            CSR_FILTER_GAIN: gain_in  = csr_data[GAIN_W-1:0];
            CSR_NARROW_MASK: mask_in  = csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RST;
         gain_ff  <= GAIN_RST;
         mask_ff  <= MASK_RST;
      end else begin
         scale_ff <= scale_in;
         gain_ff  <= gain_in;
         mask_ff  <= mask_in;
      end
   end

   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   // samples for absent channels are taken and dropped
   assign start     = accept && (int'(req_channel) < CHANNELS);

   esp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_stall (rsp_stall),
      .ctrl      (ctrl),
      .ready     (ready),
      .rsp_valid (rsp_valid)
   );

   esp_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .in_channel  (req_channel),
      .in_count    (req_count_value),
      .speed_scale (scale_ff),
      .filter_gain (gain_ff),
      .narrow_mask (mask_ff),
      .ctrl        (ctrl),
      .out_channel (rsp_channel_out),
      .out_raw     (rsp_unfiltered_speed),
      .out_smooth  (rsp_smooth_speed)
   );

endmodule

`default_nettype wire

// ===== rtl/core/esp_checker.sv =====
// ----------------------------------------------------------------------------
// esp_checker
// Port-level checks of the speed estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_speed_estimator_macros.svh"

module esp_checker import esp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [CH_W-1:0]       rsp_channel_out,
   input wire logic [SPD_W-1:0]      rsp_unfiltered_speed,
   input wire logic [SPD_W-1:0]      rsp_smooth_speed
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result beat holds
   `ESP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_channel_out) && $stable(rsp_unfiltered_speed)
      && $stable(rsp_smooth_speed), "esp: stalled result changed")

   // one sample at a time: input closes right after a beat
   `ESP_ASSERT_NEXT(a_req_busy, clock, reset, req_beat, req_stall,
      "esp: second sample taken while busy")

   // no result rises too early after a sample was taken
   `ESP_ASSERT_NEXT(a_no_early_rsp, clock, reset, $past(req_beat),
      !$rose(rsp_valid), "esp: result too early")

endmodule

bind encoder_speed_estimator esp_checker u_esp_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for encoder_speed_estimator. Samples go in through a
// queue-fed driver, results are checked one by one against a local model of
// the delta fold, Q8.16 scaling, saturation and EMA filter.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import esp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 21;
   localparam int RAND_PER_SET = 115;
   localparam int NUM_SETS    = 6;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [CH_W-1:0]  channel;
      logic [CNT_W-1:0] count;
   } enc_sample_type;

   typedef struct {
      logic [CH_W-1:0]         channel;
      logic signed [SPD_W-1:0] raw;
      logic signed [SPD_W-1:0] smooth;
   } speed_beat_type;

   typedef struct {
      logic [CSR_DATA_W-1:0] scale;
      logic [CSR_DATA_W-1:0] gain;
      logic [MASK_W-1:0]     mask;
   } csr_setting_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [CH_W-1:0]         req_channel;
   logic [CNT_W-1:0]        req_count_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CH_W-1:0]         rsp_channel_out;
   logic signed [SPD_W-1:0] rsp_unfiltered_speed;
   logic signed [SPD_W-1:0] rsp_smooth_speed;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // model state and register shadows
   logic [SCALE_W-1:0]      scale_q;
   logic [GAIN_W-1:0]       gain_q;
   logic [MASK_W-1:0]       narrow_q;
   logic [CNT_W-1:0]        last_count [CHANNELS];
   logic signed [SPD_W-1:0] filt_state [CHANNELS];

   // stimulus-side view of each channel's counter
   logic [CNT_W-1:0]        gen_count [CHANNELS];

   enc_sample_type pending_samples[$];
   speed_beat_type expected_speeds[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   encoder_speed_estimator i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_channel          (req_channel),
      .req_count_value      (req_count_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_channel_out      (rsp_channel_out),
      .rsp_unfiltered_speed (rsp_unfiltered_speed),
      .rsp_smooth_speed     (rsp_smooth_speed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   function automatic logic signed [SPD_W-1:0] clamp32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF))
         return 32'sh7FFF_FFFF;
      if (v < -longint'(32'sh7FFF_FFFF) - 1)
         return 32'sh8000_0000;
      return v[SPD_W-1:0];
   endfunction

   function automatic speed_beat_type predict_speed(input enc_sample_type s);
      speed_beat_type          r;
      logic [CNT_W-1:0]        diff;
      logic signed [15:0]      d16;
      logic signed [31:0]      d32;
      longint                  delta;
      longint                  raw_l;
      longint                  old_l;
      longint                  g;
      longint                  sum;
      diff = s.count - last_count[s.channel];
      d16  = diff[15:0];
      d32  = diff;
      if (narrow_q[s.channel])
         delta = d16;
      else
         delta = d32;
      r.channel = s.channel;
      r.raw     = clamp32(-(delta * longint'(scale_q)));
      raw_l     = r.raw;
      old_l     = filt_state[s.channel];
      g         = (gain_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_q);
      sum       = g * raw_l + (longint'(GAIN_ONE) - g) * old_l;
      // round half up, then back to Q15.16
      r.smooth  = clamp32((sum + 64'sd32768) >>> FRAC_W);
      filt_state[s.channel] = r.smooth;
      last_count[s.channel] = s.count;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // request driver: holds the beat while stalled, pops it once taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_channel     <= '0;
         req_count_value <= '0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_speeds.push_back(predict_speed(pending_samples[0]));
            void'(pending_samples.pop_front());
         end
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_channel     <= pending_samples[0].channel;
            req_count_value <= pending_samples[0].count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      speed_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               report_mismatch($sformatf("result beat ch %0d with none expected",
                                         rsp_channel_out));
            end else begin
               want = expected_speeds.pop_front();
               if (rsp_channel_out !== want.channel)
                  report_mismatch($sformatf("channel_out got %0d exp %0d",
                                            rsp_channel_out, want.channel));
               if (rsp_unfiltered_speed !== want.raw)
                  report_mismatch($sformatf("ch %0d unfiltered speed got %0d exp %0d",
                                            want.channel, rsp_unfiltered_speed,
                                            want.raw));
               if (rsp_smooth_speed !== want.smooth)
                  report_mismatch($sformatf("ch %0d smooth_speed got %0d exp %0d",
                                            want.channel, rsp_smooth_speed, want.smooth));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** encoder_speed_estimator: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SPEED_SCALE: scale_q  = data[SCALE_W-1:0];
         CSR_FILTER_GAIN: gain_q   = data[GAIN_W-1:0];
         CSR_NARROW_MASK: narrow_q = data[MASK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending_samples.size() != 0 || expected_speeds.size() != 0);
   endtask

   task automatic push_sample(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] cnt);
      enc_sample_type s;
      s.channel = ch;
      s.count   = cnt;
      gen_count[ch] = cnt;
      pending_samples.push_back(s);
   endtask

   // mostly plausible encoder motion, with wraps, jumps and raw noise mixed in
   task automatic push_random_sample();
      logic [CH_W-1:0]  ch;
      logic [CNT_W-1:0] cnt;
      int               k;
      int               step;
      ch   = CH_W'($urandom_range(CHANNELS-1));
      k    = $urandom_range(99);
      step = 0;
      if (k < 55)
         step = $urandom_range(1500);
      else if (k < 70)
         step = $urandom_range(70000);
      else if (k < 88)
         step = 0;
      else if (k < 95)
         step = 0;
      else
         step = $urandom_range(32'h7FFF_FFFF);
      if ($urandom_range(1))
         step = -step;
      if (k >= 70 && k < 80)
         cnt = $urandom;
      else if (k >= 80 && k < 88)
         cnt = (k[0] ? 32'h7FFF_FF00 : 32'hFFFF_FF00) + $urandom_range(511);
      else
         cnt = gen_count[ch] + CNT_W'(step);
      push_sample(ch, cnt);
   endtask

   initial begin
      csr_setting_type sets [NUM_SETS];
      int              i;
      int              n;
      reset           <= 1'b1;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      scale_q  = SCALE_RST;
      gain_q   = GAIN_RST;
      narrow_q = MASK_RST;
      for (i = 0; i < CHANNELS; i++) begin
         last_count[i] = '0;
         filt_state[i] = '0;
         gen_count[i]  = '0;
      end

      sets[0] = '{24'hFF_FFFF, 24'd65536, 4'hF};
      sets[1] = '{24'd0, 24'd0, 4'h0};
      sets[2] = '{24'd205783, 24'hFF_FFFF, 4'b0101};   // gain above one
      sets[3] = '{CSR_DATA_W'($urandom), 24'd65537, 4'b1010};
      sets[4] = '{24'd1, 24'd1, 4'b1100};
      sets[5] = '{24'd65536, 24'd32768, 4'b0011};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 82;

      // directed beats on reset settings: zero, unit and full-scale deltas,
      // 32-bit wrap on wide channels, 16-bit fold on narrow ones
      push_sample(2'd0, 32'h0000_0000);
      push_sample(2'd0, 32'h0000_0001);
      push_sample(2'd0, 32'h0000_0000);
      push_sample(2'd0, 32'hFFFF_FFFF);
      push_sample(2'd0, 32'h7FFF_FFFF);
      push_sample(2'd0, 32'hFFFF_FFFF);
      push_sample(2'd0, 32'h8000_0000);
      push_sample(2'd0, 32'h0000_0000);
      push_sample(2'd1, 32'h0001_0000);
      push_sample(2'd1, 32'h0000_0000);
      push_sample(2'd1, 32'hAAAA_AAAA);
      push_sample(2'd1, 32'h5555_5555);
      push_sample(2'd2, 32'h0000_7FFF);
      push_sample(2'd2, 32'h0000_FFFF);
      push_sample(2'd2, 32'h0001_0000);
      push_sample(2'd2, 32'h0001_FFFF);
      push_sample(2'd2, 32'h1234_8000);
      push_sample(2'd3, 32'hFFFF_8000);
      push_sample(2'd3, 32'h0000_7FFF);
      push_sample(2'd3, 32'h0000_0000);
      push_sample(2'd3, 32'h0000_0000);
      wait_drained();

      for (n = 0; n < NUM_SETS; n++) begin
         if (n == 2) begin
            send_idle_pct = 82;
            recv_idle_pct = 37;
         end else if (n == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(CSR_SPEED_SCALE, sets[n].scale);
         csr_write(CSR_FILTER_GAIN, sets[n].gain);
         // upper data bits carry noise; only the mask bits land
         csr_write(CSR_NARROW_MASK, {(CSR_DATA_W-MASK_W)'($urandom), sets[n].mask});
         if (n == 1 || n == 3)
            csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
         for (i = 0; i < RAND_PER_SET; i++)
            push_random_sample();
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_speeds.size() == 0)
         $display("** encoder_speed_estimator: PASSED **");
      else
         $display("** encoder_speed_estimator: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
